### rtl/wmph_pkg.sv
package wmph_pkg;

  localparam int MAX_WINDOW  = 1024;
  localparam int SAMPLE_BITS = 24;
  localparam int MAG_W       = SAMPLE_BITS - 1;
  localparam int ADDR_W      = $clog2(MAX_WINDOW);
  localparam int LEN_W       = ADDR_W + 1;

  localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_READ
  } wmph_state_t;

  typedef struct packed {
    logic clr_step;
    logic accept;
    logic wr_push;
    logic scan_step;
    logic peak_update;
    logic rd_load;
  } wmph_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic scan_last;
    logic out_free;
  } wmph_stat_t;

endpackage

### rtl/wmph_if.sv
interface wmph_item_if
  import wmph_pkg::*;
();
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source(output valid, output cmd, output sample, input ready);
  modport sink(input valid, input cmd, input sample, output ready);
endinterface

interface wmph_result_if
  import wmph_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [MAG_W-1:0] peak_level;

  modport source(output valid, output peak_level, input ready);
  modport sink(input valid, input peak_level, output ready);
endinterface

### rtl/wmph_ram.sv
module wmph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/wmph_ctrl.sv
module wmph_ctrl
  import wmph_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_cmd,
  output logic       in_ready,
  input  wmph_stat_t stat,
  output wmph_cmd_t  cmd
);

  wmph_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (stat.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = (in_cmd == CMD_READ) ? ST_READ : ST_WRITE;
      end
      ST_WRITE:  state_next = ST_SCAN;
      ST_SCAN: begin
        if (stat.scan_last) state_next = ST_DRAIN;
      end
      ST_DRAIN:  state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_IDLE;
      ST_READ: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_CLEAR:  cmd.clr_step = 1'b1;
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_WRITE:  cmd.wr_push = 1'b1;
      ST_SCAN:   cmd.scan_step = 1'b1;
      ST_DRAIN:  ;
      ST_UPDATE: cmd.peak_update = 1'b1;
      ST_READ:   cmd.rd_load = stat.out_free;
      default:   ;
    endcase
  end

endmodule

### rtl/wmph_dp.sv
module wmph_dp
  import wmph_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [LEN_W-1:0]              cfg_wdata,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [MAG_W-1:0]              out_peak_level,
  input  wmph_cmd_t                     cmd,
  output wmph_stat_t                    stat
);

  logic [LEN_W-1:0]       window_length;
  logic [LEN_W-1:0]       len_eff;
  logic [ADDR_W-1:0]      wp, wp_cur, wp_next;
  logic [LEN_W-1:0]       wp_inc;
  logic [ADDR_W-1:0]      idx;
  logic                   scan_vld;
  logic [MAG_W-1:0]       least;
  logic [MAG_W-1:0]       held_peak;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic [SAMPLE_BITS-1:0] neg;
  logic [MAG_W-1:0]       mag;
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [MAG_W-1:0]       ram_wdata;
  logic [MAG_W-1:0]       ram_rdata;

  always_comb begin
    if (window_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (window_length > LEN_W'(MAX_WINDOW)) begin
      len_eff = LEN_W'(MAX_WINDOW);
    end else begin
      len_eff = window_length;
    end
  end

  // position falls back to entry zero after the window shrank
  assign wp_cur  = ({1'b0, wp} >= len_eff) ? '0 : wp;
  assign wp_inc  = {1'b0, wp_cur} + LEN_W'(1);
  assign wp_next = (wp_inc >= len_eff) ? '0 : wp_inc[ADDR_W-1:0];

  // most negative code saturates
  assign neg = -sample_q;
  always_comb begin
    if (!sample_q[SAMPLE_BITS-1]) begin
      mag = sample_q[MAG_W-1:0];
    end else if (neg[SAMPLE_BITS-1]) begin
      mag = MAG_MAX;
    end else begin
      mag = neg[MAG_W-1:0];
    end
  end

  assign ram_we    = cmd.clr_step | cmd.wr_push;
  assign ram_waddr = cmd.wr_push ? wp_cur : idx;
  assign ram_wdata = cmd.wr_push ? mag : '0;

  wmph_ram #(
    .WIDTH(MAG_W),
    .DEPTH(MAX_WINDOW)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(idx),
    .rdata(ram_rdata)
  );

  assign stat.clr_last  = (idx == ADDR_W'(MAX_WINDOW - 1));
  assign stat.scan_last = ({1'b0, idx} == (len_eff - LEN_W'(1)));
  assign stat.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= LEN_W'(1);
      wp            <= '0;
      idx           <= '0;
      scan_vld      <= 1'b0;
      held_peak     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_length <= cfg_wdata;
      end
      if (cmd.wr_push) begin
        wp  <= wp_next;
        idx <= '0;
      end else if (cmd.clr_step || cmd.scan_step) begin
        idx <= idx + ADDR_W'(1);
      end
      scan_vld <= cmd.scan_step;
      if (cmd.rd_load) begin
        held_peak <= '0;
      end else if (cmd.peak_update && least > held_peak) begin
        held_peak <= least;
      end
      if (cmd.rd_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_q <= in_sample;
    end
    if (cmd.wr_push) begin
      least <= MAG_MAX;
    end else if (scan_vld && ram_rdata < least) begin
      least <= ram_rdata;
    end
    if (cmd.rd_load) begin
      out_peak_level <= held_peak;
    end
  end

endmodule

### rtl/windowed_min_peak_hold.sv
// channel  dir  word                        note
// item     in   cmd, sample (s24 Q1.23)     cmd 0 push, 1 read and clear
// result   out  peak_level (u23 Q0.23)      one word per read
// cfg      in   cfg_we, cfg_wdata (u11)     window_length, write while idle
//
// Push: accept, write, one scan read per effective window entry, then drain and
// update; one RAM read per cycle. Read: accept, then load once the result slot is free.
// After rst the 1024-entry ring is zeroed; item.ready stays low meanwhile.
// The result register frees item.ready from result.ready; a read waits for it.
module windowed_min_peak_hold
  import wmph_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata,
  wmph_item_if.sink        item,
  wmph_result_if.source    result
);

  wmph_cmd_t  cmd;
  wmph_stat_t stat;

  wmph_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(item.valid),
    .in_cmd  (item.cmd),
    .in_ready(item.ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  wmph_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_sample     (item.sample),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .out_peak_level(result.peak_level),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule
